>>> rtl/mua_pkg.sv
// Package for the ungapped alignment filter: sizes, score type, sequencer states
// and the control group passed to the update cell. No dependencies.
package mua_pkg;

    localparam int MAX_MODEL_LEN = 1024;
    localparam int ALPHABET_SIZE = 32;
    localparam int POS_W         = $clog2(MAX_MODEL_LEN);
    localparam int LEN_W         = POS_W + 1;
    localparam int RES_W         = $clog2(ALPHABET_SIZE);
    localparam int SCORE_W       = 8;
    localparam int TABLE_DEPTH   = ALPHABET_SIZE * MAX_MODEL_LEN;
    localparam int TABLE_AW      = RES_W + POS_W;

    typedef logic [SCORE_W-1:0] score_t;

    // Configuration register indexes.
    localparam logic [2:0] REG_MODEL_LENGTH  = 3'd0;
    localparam logic [2:0] REG_EMISSION_BIAS = 3'd1;
    localparam logic [2:0] REG_SCORE_BASE    = 3'd2;
    localparam logic [2:0] REG_COST_TJB      = 3'd3;
    localparam logic [2:0] REG_COST_TBM      = 3'd4;
    localparam logic [2:0] REG_COST_TEC      = 3'd5;

    // Command codes.
    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_PROCESS = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_FINISH
    } seq_state_t;

    // Control for the update cell at the head of the chain.
    typedef struct packed {
        logic valid;   // a model position is at the head this cycle
        logic start;   // position zero: no left neighbour, row maximum restarts
        logic active;  // position lies inside the model length
        logic clear;   // new sequence: old row content reads as zero
    } head_ctrl_t;

endpackage

>>> rtl/mua_cell.sv
// One storage cell of the circulating row of match scores.
// Depends on mua_pkg.
module mua_cell
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           shift,
    input  mua_pkg::score_t d_in,
    output mua_pkg::score_t q
);
    import mua_pkg::*;

    score_t score_reg;

    // The cell takes its neighbour's score whenever the row advances.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            score_reg <= '0;
        end
        else if (shift)
        begin
            score_reg <= d_in;
        end
    end

    assign q = score_reg;

endmodule

>>> rtl/mua_head.sv
// Update cell at the head of the chain: computes one new match score per cycle
// while ctrl.valid is high, and keeps the left neighbour and the running row maximum. Depends on mua_pkg.
module mua_head
(
    input  logic             clk,
    input  logic             rst_n,
    input  mua_pkg::head_ctrl_t ctrl,
    input  mua_pkg::score_t  old_score,
    input  mua_pkg::score_t  cost,
    input  mua_pkg::score_t  bias,
    input  mua_pkg::score_t  entry,
    output mua_pkg::score_t  new_score,
    output mua_pkg::score_t  row_max
);
    import mua_pkg::*;

    score_t prev_reg;
    score_t prev_next;
    score_t emax_reg;
    score_t emax_next;
    score_t old_eff;
    score_t prev_eff;
    score_t emax_eff;
    score_t best;
    logic [SCORE_W:0] biased;
    score_t sat;
    score_t sv;

    // Score of the cell: best entry, bias with saturation, cost floored at zero.
    always_comb
    begin
        old_eff   = ctrl.clear ? '0 : old_score;
        prev_eff  = ctrl.start ? '0 : prev_reg;
        emax_eff  = ctrl.start ? '0 : emax_reg;
        best      = (prev_eff > entry) ? prev_eff : entry;
        biased    = {1'b0, best} + {1'b0, bias};
        sat       = biased[SCORE_W] ? {SCORE_W{1'b1}} : biased[SCORE_W-1:0];
        sv        = (sat >= cost) ? (sat - cost) : '0;
        new_score = ctrl.active ? sv : old_eff;
        prev_next = old_eff;
        if (ctrl.active && (sv > emax_eff))
        begin
            emax_next = sv;
        end
        else
        begin
            emax_next = emax_eff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
            emax_reg <= '0;
        end
        else if (ctrl.valid)
        begin
            prev_reg <= prev_next;
            emax_reg <= emax_next;
        end
    end

    assign row_max = emax_reg;

endmodule

>>> rtl/msv_ungapped_alignment_filter_unit.sv
// Top level of the ungapped alignment filter: APB registers, emission cost
// memory, sequencer, chain of row cells and head update cell.
// Depends on mua_pkg, mua_cell and mua_head.
//
//   Channel   Handshake          Payload
//   config    psel/penable/pwrite paddr, pwdata, prdata
//   item in   start & !busy      command, residue, model_position, cost_value,
//                                first_residue, last_residue
//   result    done (one cycle)   status, final_c_score
//
// A load item does not make the block busy. A process item rotates the whole row
// of 1024 cells once past the update cell, one position per cycle, followed by
// the registered cost memory read and the update of the specials.
// A process item after overflow in the same sequence skips the sweep.
// Reset clears the row, the specials and the registers; the cost memory is not
// cleared. Results cannot be stalled by the receiver.
module msv_ungapped_alignment_filter_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic        command,
    input  logic [4:0]  residue,
    input  logic [9:0]  model_position,
    input  logic [7:0]  cost_value,
    input  logic        first_residue,
    input  logic        last_residue,
    output logic        done,
    output logic        status,
    output logic [7:0]  final_c_score
);
    import mua_pkg::*;

    // Configuration registers.
    logic [LEN_W-1:0] model_length_reg;
    score_t bias_reg;
    score_t base_reg;
    score_t tjb_reg;
    score_t tbm_reg;
    score_t tec_reg;
    logic   cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            model_length_reg <= LEN_W'(1);
            bias_reg         <= '0;
            base_reg         <= '0;
            tjb_reg          <= '0;
            tbm_reg          <= '0;
            tec_reg          <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                REG_MODEL_LENGTH:  model_length_reg <= pwdata[LEN_W-1:0];
                REG_EMISSION_BIAS: bias_reg         <= pwdata[SCORE_W-1:0];
                REG_SCORE_BASE:    base_reg         <= pwdata[SCORE_W-1:0];
                REG_COST_TJB:      tjb_reg          <= pwdata[SCORE_W-1:0];
                REG_COST_TBM:      tbm_reg          <= pwdata[SCORE_W-1:0];
                REG_COST_TEC:      tec_reg          <= pwdata[SCORE_W-1:0];
                default:           ;
            endcase
        end
    end

    // Register read back.
    always_comb
    begin
        unique case (paddr[4:2])
            REG_MODEL_LENGTH:  prdata = 32'(model_length_reg);
            REG_EMISSION_BIAS: prdata = 32'(bias_reg);
            REG_SCORE_BASE:    prdata = 32'(base_reg);
            REG_COST_TJB:      prdata = 32'(tjb_reg);
            REG_COST_TBM:      prdata = 32'(tbm_reg);
            REG_COST_TEC:      prdata = 32'(tec_reg);
            default:           prdata = '0;
        endcase
    end

    // Sequencer and item state.
    seq_state_t state_reg;
    seq_state_t state_next;
    logic       accept;
    logic       accept_proc;
    logic       skip_now;
    logic [POS_W-1:0] cnt_reg;
    logic       stg_valid_reg;
    logic [POS_W-1:0] stg_k_reg;
    logic [RES_W-1:0] res_reg;
    logic       last_reg;
    logic       clear_reg;
    logic       skip_reg;
    score_t     entry_reg;
    score_t     c_reg;
    score_t     b_reg;
    logic       ovf_reg;
    score_t     b_start;
    logic       issue;
    logic       sweep_end;

    assign accept      = start && !busy;
    assign accept_proc = accept && (command == CMD_PROCESS);
    assign skip_now    = !first_residue && ovf_reg;
    assign b_start     = first_residue ? (base_reg - tjb_reg) : b_reg;
    assign sweep_end   = (cnt_reg == POS_W'(MAX_MODEL_LEN - 1));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept_proc)
                begin
                    state_next = skip_now ? ST_FINISH : ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                if (sweep_end)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:  state_next = ST_FINISH;
            ST_FINISH: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb
    begin
        busy  = (state_reg != ST_IDLE);
        issue = (state_reg == ST_SWEEP);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            stg_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= issue ? cnt_reg + POS_W'(1) : '0;
            stg_valid_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        stg_k_reg <= cnt_reg;
        if (accept_proc)
        begin
            res_reg   <= residue;
            last_reg  <= last_residue;
            clear_reg <= first_residue;
            skip_reg  <= skip_now;
            entry_reg <= b_start - tbm_reg;
        end
    end

    // Emission cost memory: written by load items, read once per position.
    score_t cost_mem [TABLE_DEPTH];
    score_t cost_rd_reg;

    always_ff @(posedge clk)
    begin
        if (accept && (command == CMD_LOAD))
        begin
            cost_mem[{residue, model_position}] <= cost_value;
        end
        if (issue)
        begin
            cost_rd_reg <= cost_mem[{res_reg, cnt_reg}];
        end
    end

    // Chain of row cells; the head cell feeds the updated score into the tail.
    score_t     cell_q [MAX_MODEL_LEN];
    score_t     head_new;
    score_t     row_max;
    head_ctrl_t ctrl;

    assign ctrl.valid  = stg_valid_reg;
    assign ctrl.start  = (stg_k_reg == '0);
    assign ctrl.active = ({1'b0, stg_k_reg} < model_length_reg);
    assign ctrl.clear  = clear_reg;

    for (genvar i = 0; i < MAX_MODEL_LEN; i++)
    begin : g_cell
        if (i == MAX_MODEL_LEN - 1)
        begin : g_tail
            mua_cell u_cell
            (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (stg_valid_reg),
                .d_in  (head_new),
                .q     (cell_q[i])
            );
        end
        else
        begin : g_body
            mua_cell u_cell
            (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (stg_valid_reg),
                .d_in  (cell_q[i+1]),
                .q     (cell_q[i])
            );
        end
    end

    mua_head u_head
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .old_score (cell_q[0]),
        .cost      (cost_rd_reg),
        .bias      (bias_reg),
        .entry     (entry_reg),
        .new_score (head_new),
        .row_max   (row_max)
    );

    // Special states after the sweep, and the result.
    logic   ovf_hit;
    score_t c_cand;
    score_t c_new;
    score_t b_max;
    logic   finish;

    assign finish  = (state_reg == ST_FINISH);
    assign ovf_hit = (row_max >= ~bias_reg);
    assign c_cand  = row_max - tec_reg;
    assign c_new   = ((row_max > tec_reg) && (c_cand > c_reg)) ? c_cand : c_reg;
    assign b_max   = (base_reg > c_new) ? base_reg : c_new;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_reg   <= '0;
            b_reg   <= '0;
            ovf_reg <= 1'b0;
            done    <= 1'b0;
        end
        else
        begin
            if (accept_proc && first_residue)
            begin
                c_reg   <= '0;
                b_reg   <= base_reg - tjb_reg;
                ovf_reg <= 1'b0;
            end
            else if (finish && !skip_reg)
            begin
                if (ovf_hit)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    c_reg <= c_new;
                    b_reg <= b_max - tjb_reg;
                end
            end
            done <= finish && last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            if (skip_reg || ovf_hit)
            begin
                status        <= 1'b1;
                final_c_score <= '0;
            end
            else
            begin
                status        <= 1'b0;
                final_c_score <= c_new;
            end
        end
    end

endmodule

>>> sim/mua_score_checker.sv
// Checker for the ungapped alignment filter: watches the register port, the item
// and result channels, predicts each outcome and compares it. Depends on mua_pkg.
module mua_score_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        start,
    input  logic        busy,
    input  logic        command,
    input  logic [4:0]  residue,
    input  logic [9:0]  model_position,
    input  logic [7:0]  cost_value,
    input  logic        first_residue,
    input  logic        last_residue,
    input  logic        done,
    input  logic        status,
    input  logic [7:0]  final_c_score,
    output int          pending,
    output int          errors
);
    import mua_pkg::*;

    typedef struct packed {
        logic   hit;
        score_t score;
    } outcome_t;

    outcome_t     outcome_q[$];
    score_t       row_mem[MAX_MODEL_LEN];
    score_t       cost_mem[TABLE_DEPTH];
    logic [10:0]  model_len_r;
    score_t       bias_r;
    score_t       base_r;
    score_t       tjb_r;
    score_t       tbm_r;
    score_t       tec_r;
    score_t       c_score;
    score_t       b_score;
    logic         overflow;

    assign pending = outcome_q.size();

    // One pass of the row for a residue, then the update of the specials.
    function automatic void sweep_residue(input logic [RES_W-1:0] res);
        int len;
        int entry;
        int left;
        int old;
        int cur;
        int row_max;
        int cost;
        int top;
        len     = (model_len_r > MAX_MODEL_LEN) ? MAX_MODEL_LEN : int'(model_len_r);
        entry   = (int'(b_score) - int'(tbm_r)) & 8'hFF;
        left    = 0;
        row_max = 0;
        for (int k = 0; k < len; k++)
        begin
            old  = row_mem[k];
            cur  = (left > entry) ? left : entry;
            cur  = cur + bias_r;
            if (cur > 255)
                cur = 255;
            cost = cost_mem[{res, k[POS_W-1:0]}];
            cur  = (cur >= cost) ? cur - cost : 0;
            if (cur > row_max)
                row_max = cur;
            row_mem[k] = score_t'(cur);
            left = old;
        end
        if (row_max >= 255 - int'(bias_r))
        begin
            overflow = 1'b1;
        end
        else
        begin
            if (row_max > tec_r && row_max - int'(tec_r) > c_score)
                c_score = score_t'(row_max - int'(tec_r));
            top     = (base_r > c_score) ? base_r : c_score;
            b_score = score_t'(top - int'(tjb_r));
        end
    endfunction

    // Track registers, predict accepted items and compare results.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            model_len_r = 11'd1;
            bias_r      = '0;
            base_r      = '0;
            tjb_r       = '0;
            tbm_r       = '0;
            tec_r       = '0;
            c_score     = '0;
            b_score     = '0;
            overflow    = 1'b0;
            errors      = 0;
            outcome_q.delete();
            foreach (row_mem[k])
                row_mem[k] = '0;
        end
        else
        begin
            if (done)
            begin
                if (outcome_q.size() == 0)
                begin
                    $error("result with no item outstanding: status %0d, final_c_score %0d",
                           status, final_c_score);
                    errors++;
                end
                else
                begin
                    outcome_t want;
                    want = outcome_q.pop_front();
                    if (status !== want.hit)
                    begin
                        $error("status: expected %0d, actual %0d", want.hit, status);
                        errors++;
                    end
                    if (final_c_score !== want.score)
                    begin
                        $error("final_c_score: expected %0d, actual %0d",
                               want.score, final_c_score);
                        errors++;
                    end
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    REG_MODEL_LENGTH:  model_len_r = pwdata[10:0];
                    REG_EMISSION_BIAS: bias_r      = pwdata[7:0];
                    REG_SCORE_BASE:    base_r      = pwdata[7:0];
                    REG_COST_TJB:      tjb_r       = pwdata[7:0];
                    REG_COST_TBM:      tbm_r       = pwdata[7:0];
                    REG_COST_TEC:      tec_r       = pwdata[7:0];
                    default: ;
                endcase
            end
            if (start && !busy)
            begin
                if (command == CMD_LOAD)
                begin
                    cost_mem[{residue, model_position}] = cost_value;
                end
                else
                begin
                    if (first_residue)
                    begin
                        foreach (row_mem[k])
                            row_mem[k] = '0;
                        c_score  = '0;
                        b_score  = base_r - tjb_r;
                        overflow = 1'b0;
                    end
                    if (!overflow)
                        sweep_residue(residue);
                    if (last_residue)
                        outcome_q.push_back(overflow ? outcome_t'{1'b1, 8'd0}
                                                     : outcome_t'{1'b0, c_score});
                end
            end
        end
    end

endmodule

>>> sim/testbench.sv
// Top of the ungapped alignment filter testbench: clock, reset, register writes
// and item stimulus, watchdog and verdict. Depends on mua_pkg, mua_score_checker
// and the block itself.
module testbench;
    import mua_pkg::*;

    localparam int WATCHDOG_LIMIT = 6000;
    localparam int SETTLE_CYCLES  = 1100;
    localparam int FILL_RES       = 4;
    localparam int FILL_LEN       = 32;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        start = 1'b0;
    logic        busy;
    logic        command = CMD_LOAD;
    logic [4:0]  residue = '0;
    logic [9:0]  model_position = '0;
    logic [7:0]  cost_value = '0;
    logic        first_residue = 1'b0;
    logic        last_residue = 1'b0;
    logic        done;
    logic        status;
    logic [7:0]  final_c_score;
    int          pending;
    int          errors;
    int          quiet_cycles = 0;
    int          idle_pct = 0;

    msv_ungapped_alignment_filter_unit uut (.*);

    mua_score_checker checker_i (.*);

    // Clock.
    initial
    begin
        forever #6 clk = ~clk;
    end

    // Watchdog: any handshake on any channel counts as progress.
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[msv_ungapped_alignment_filter_unit] ERROR");
            $finish;
        end
    end

    // Residue codes whose cost rows are loaded before any sweep.
    function automatic logic [4:0] res_code(input int idx);
        logic [4:0] code;
        unique case (idx)
            0:       code = 5'd0;
            1:       code = 5'd3;
            2:       code = 5'd7;
            default: code = 5'd31;
        endcase
        return code;
    endfunction

    function automatic logic [4:0] pick_res();
        return res_code(int'($urandom_range(0, FILL_RES - 1)));
    endfunction

    // Register write: setup cycle, access cycle, then an idle cycle.
    task automatic write_reg(input logic [2:0] idx, input int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one item and hold it until the block takes it.
    task automatic send_item(input logic cmd, input logic [4:0] res, input logic [9:0] pos,
                             input logic [7:0] cost, input logic first, input logic last);
        logic taken;
        command        <= cmd;
        residue        <= res;
        model_position <= pos;
        cost_value     <= cost;
        first_residue  <= first;
        last_residue   <= last;
        start          <= 1'b1;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end
        // Random gap before the next item.
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct)
                @(posedge clk);
        end
    endtask

    // Wait until the block is idle and every outcome is in.
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input int unsigned len, input int unsigned bias,
                              input int unsigned base, input int unsigned tjb,
                              input int unsigned tbm, input int unsigned tec);
        wait_idle();
        write_reg(REG_MODEL_LENGTH, len);
        write_reg(REG_EMISSION_BIAS, bias);
        write_reg(REG_SCORE_BASE, base);
        write_reg(REG_COST_TJB, tjb);
        write_reg(REG_COST_TBM, tbm);
        write_reg(REG_COST_TEC, tec);
    endtask

    // Random mix: mostly well-formed sequences, some stray loads and broken ones.
    task automatic random_items(input int count);
        int sent;
        int seq_len;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(99) < 80)
            begin
                seq_len = $urandom_range(1, 5);
                for (int i = 0; i < seq_len; i++)
                begin
                    if ($urandom_range(99) < 15)
                    begin
                        send_item(CMD_LOAD, 5'($urandom), 10'($urandom), 8'($urandom),
                                  1'($urandom), 1'($urandom));
                        sent++;
                    end
                    send_item(CMD_PROCESS, pick_res(), 10'($urandom), 8'($urandom),
                              i == 0, i == seq_len - 1);
                    sent++;
                end
            end
            else
            begin
                send_item(1'($urandom), pick_res(), 10'($urandom), 8'($urandom),
                          1'($urandom), 1'($urandom));
                sent++;
            end
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Load the cost rows of the residues in use over the model lengths in use.
        for (int r = 0; r < FILL_RES; r++)
            for (int p = 0; p < FILL_LEN; p++)
                send_item(CMD_LOAD, res_code(r), 10'(p), 8'($urandom_range(0, 60)),
                          1'b0, 1'b0);

        // Directed: processing from reset state, load extremes, ignored flags.
        send_item(CMD_PROCESS, 5'd7, 10'd0, 8'd0, 1'b0, 1'b1);
        send_item(CMD_LOAD, 5'd31, 10'd1023, 8'd255, 1'b1, 1'b1);
        send_item(CMD_LOAD, 5'd0, 10'd0, 8'd0, 1'b1, 1'b0);
        send_item(CMD_LOAD, 5'd31, 10'd0, 8'd0, 1'b0, 1'b1);
        send_item(CMD_PROCESS, 5'd0, 10'd1023, 8'd255, 1'b1, 1'b1);
        send_item(CMD_PROCESS, 5'd31, 10'd0, 8'd0, 1'b1, 1'b0);
        send_item(CMD_PROCESS, 5'd31, 10'd0, 8'd0, 1'b0, 1'b1);

        // Zero length: no position lies inside the model, so no cell is updated.
        set_config(0, 10, 40, 3, 2, 1);
        send_item(CMD_PROCESS, 5'd3, 10'd0, 8'd0, 1'b1, 1'b0);
        send_item(CMD_PROCESS, 5'd4, 10'd0, 8'd0, 1'b0, 1'b1);

        // Very high bias: every sweep overflows, later residues are ignored.
        set_config(16, 255, 0, 255, 0, 0);
        send_item(CMD_PROCESS, 5'd0, 10'd0, 8'd0, 1'b1, 1'b0);
        send_item(CMD_PROCESS, 5'd2, 10'd0, 8'd0, 1'b0, 1'b0);
        send_item(CMD_PROCESS, 5'd3, 10'd0, 8'd0, 1'b0, 1'b1);

        // Random phases with different registers and sender gaps.
        idle_pct = 0;
        set_config(FILL_LEN, 0, 255, 0, 255, 255);
        random_items(60);
        idle_pct = 71;
        set_config($urandom_range(1, FILL_LEN), $urandom_range(0, 80), $urandom, $urandom,
                   $urandom, $urandom);
        random_items(60);
        idle_pct = 0;
        set_config($urandom_range(1, FILL_LEN), $urandom_range(20, 90), $urandom_range(0, 255),
                   $urandom_range(0, 30), $urandom_range(0, 30), $urandom_range(0, 30));
        random_items(60);
        idle_pct = 25;
        set_config(1, 255, 255, 255, 255, 255);
        random_items(30);
        idle_pct = 71;
        set_config($urandom_range(0, FILL_LEN), $urandom_range(0, 120), $urandom, $urandom,
                   $urandom, $urandom);
        random_items(60);

        wait_idle();
        if (errors == 0 && pending == 0)
            $display("[msv_ungapped_alignment_filter_unit] OK");
        else
            $display("[msv_ungapped_alignment_filter_unit] ERROR");
        $finish;
    end

endmodule
